>>> rtl/gtpt_pkg.sv
// Shared types and constants of the gate time position tracker.
// Holds request codes, speed codes, register indexes and the tracker state record.
// Depends on nothing.
`default_nettype none

package gtpt_pkg;

    localparam int POS_W      = 32;
    localparam int MARGIN_W   = 14;
    localparam int REQ_W      = 3;
    localparam int CMD_W      = 2;
    localparam int CFG_ADDR_W = 1;

    localparam logic [POS_W-1:0] BASE_OFFSET = 32'd10000;

    localparam logic [MARGIN_W-1:0] SLOW_MARGIN_RST   = 14'd1000;
    localparam logic [MARGIN_W-1:0] SAFETY_MARGIN_RST = 14'd5000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_MARGIN   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAFETY_MARGIN = 1'b1;

    localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LEARN     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COMMIT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLOSE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_OPEN      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_MID_CLOSE = 3'd6;
    localparam logic [REQ_W-1:0] REQ_MID_OPEN  = 3'd7;

    localparam logic [CMD_W-1:0] SPD_KEEP = 2'd0;
    localparam logic [CMD_W-1:0] SPD_SLOW = 2'd1;
    localparam logic [CMD_W-1:0] SPD_STOP = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] start_time;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] mid_open;
        logic [POS_W-1:0] mid_close;
        logic [POS_W-1:0] end_pos;
        logic [POS_W-1:0] lim_open_slow;
        logic [POS_W-1:0] lim_open_stop;
        logic [POS_W-1:0] lim_close_slow;
        logic [POS_W-1:0] lim_close_stop;
    } t_track_state;

endpackage

`default_nettype wire

>>> rtl/gtpt_step.sv
// Combinational update of the tracker state and the speed decision for one request.
// Depends on gtpt_pkg.
`default_nettype none

module gtpt_step #(
    parameter logic [gtpt_pkg::POS_W-1:0] BASE_OFFSET = gtpt_pkg::BASE_OFFSET
) (
    input  wire gtpt_pkg::t_track_state          i_state,
    input  wire logic [gtpt_pkg::REQ_W-1:0]      i_req,
    input  wire logic [gtpt_pkg::POS_W-1:0]      i_now,
    input  wire logic [gtpt_pkg::POS_W-1:0]      i_saved,
    input  wire logic [gtpt_pkg::MARGIN_W-1:0]   i_slow_margin,
    input  wire logic [gtpt_pkg::MARGIN_W-1:0]   i_safety_margin,
    output gtpt_pkg::t_track_state               o_state,
    output logic [gtpt_pkg::CMD_W-1:0]           o_cmd
);

    function automatic logic [gtpt_pkg::POS_W-1:0] sat_add(
        input logic [gtpt_pkg::POS_W-1:0] a,
        input logic [gtpt_pkg::POS_W-1:0] b
    );
        logic [gtpt_pkg::POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[gtpt_pkg::POS_W] ? '1 : s[gtpt_pkg::POS_W-1:0];
    endfunction

    function automatic logic [gtpt_pkg::POS_W-1:0] sat_sub(
        input logic [gtpt_pkg::POS_W-1:0] a,
        input logic [gtpt_pkg::POS_W-1:0] b
    );
        return (a > b) ? (a - b) : '0;
    endfunction

    logic [gtpt_pkg::POS_W-1:0] elapsed;
    logic [gtpt_pkg::POS_W-1:0] slow_ext;
    logic [gtpt_pkg::POS_W-1:0] safety_ext;
    logic [gtpt_pkg::POS_W-1:0] new_end;
    logic [gtpt_pkg::POS_W-1:0] mid_base;
    logic [gtpt_pkg::POS_W-1:0] close_val;
    logic [gtpt_pkg::POS_W-1:0] open_val;
    logic                       do_latch;
    logic                       is_close;
    logic                       is_open;

    assign elapsed    = i_now - i_state.start_time;
    assign slow_ext   = {{(gtpt_pkg::POS_W-gtpt_pkg::MARGIN_W){1'b0}}, i_slow_margin};
    assign safety_ext = {{(gtpt_pkg::POS_W-gtpt_pkg::MARGIN_W){1'b0}}, i_safety_margin};

    always_comb begin
        o_state   = i_state;
        new_end   = i_state.end_pos;
        do_latch  = 1'b0;
        is_close  = 1'b0;
        is_open   = 1'b0;
        mid_base  = i_state.position;
        close_val = '0;
        open_val  = '0;
        unique case (i_req)
            gtpt_pkg::REQ_LOAD: begin
                new_end  = i_saved;
                do_latch = 1'b1;
            end
            gtpt_pkg::REQ_START: begin
                o_state.start_time = i_now;
            end
            gtpt_pkg::REQ_LEARN: begin
                o_state.position = elapsed;
            end
            gtpt_pkg::REQ_COMMIT: begin
                new_end  = sat_add(i_state.position, BASE_OFFSET);
                do_latch = 1'b1;
            end
            gtpt_pkg::REQ_CLOSE: begin
                o_state.mid_open  = '0;
                o_state.mid_close = '0;
                close_val         = sat_sub(i_state.end_pos, elapsed);
                o_state.position  = close_val;
                is_close          = 1'b1;
            end
            gtpt_pkg::REQ_OPEN: begin
                o_state.mid_open  = '0;
                o_state.mid_close = '0;
                open_val          = sat_add(BASE_OFFSET, elapsed);
                o_state.position  = open_val;
                is_open           = 1'b1;
            end
            gtpt_pkg::REQ_MID_CLOSE: begin
                if (i_state.mid_open != '0) begin
                    mid_base         = i_state.mid_open;
                    o_state.position = i_state.mid_open;
                end
                close_val         = sat_sub(mid_base, elapsed);
                o_state.mid_open  = '0;
                o_state.mid_close = close_val;
                is_close          = 1'b1;
            end
            gtpt_pkg::REQ_MID_OPEN: begin
                if (i_state.mid_close != '0) begin
                    mid_base         = i_state.mid_close;
                    o_state.position = i_state.mid_close;
                end
                open_val          = sat_add(mid_base, elapsed);
                o_state.mid_close = '0;
                o_state.mid_open  = open_val;
                is_open           = 1'b1;
            end
            default: begin
            end
        endcase

        o_state.end_pos = new_end;
        if (do_latch) begin
            o_state.lim_open_slow  = sat_sub(new_end, slow_ext);
            o_state.lim_open_stop  = sat_add(new_end, safety_ext);
            o_state.lim_close_slow = sat_add(BASE_OFFSET, slow_ext);
            o_state.lim_close_stop = sat_sub(BASE_OFFSET, safety_ext);
        end

        o_cmd = gtpt_pkg::SPD_KEEP;
        if (is_close) begin
            if (close_val <= i_state.lim_close_stop) begin
                o_cmd = gtpt_pkg::SPD_STOP;
            end else if (close_val <= i_state.lim_close_slow) begin
                o_cmd = gtpt_pkg::SPD_SLOW;
            end
        end else if (is_open) begin
            if (open_val >= i_state.lim_open_stop) begin
                o_cmd = gtpt_pkg::SPD_STOP;
            end else if (open_val >= i_state.lim_open_slow) begin
                o_cmd = gtpt_pkg::SPD_SLOW;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/gate_time_position_tracker.sv
// Gate time position tracker: input register, state update logic, result register.
// A request passes the input register and the state update into the result register;
// one request per cycle is sustained while the output is not stalled.
// Synchronous active-low reset clears the state, the latched limits and the valid flags
// and restores the margins to 1000 and 5000. Depends on gtpt_pkg and gtpt_step.
`default_nettype none

module gate_time_position_tracker #(
    parameter logic [gtpt_pkg::POS_W-1:0] BASE_OFFSET = gtpt_pkg::BASE_OFFSET
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [gtpt_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire logic [gtpt_pkg::MARGIN_W-1:0]         i_cfg_wdata,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // now_ms [31:0], saved_position [63:32]
    input  wire logic [63:0]                           i_s_axis_tdata,
    // req_type [2:0]
    input  wire logic [gtpt_pkg::REQ_W-1:0]            i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // speed_command [1:0], final_position [33:2], zero [39:34]
    output logic [39:0]                                o_m_axis_tdata
);

    logic                                 slow_margin_we;
    logic [gtpt_pkg::MARGIN_W-1:0]        r_slow_margin;
    logic [gtpt_pkg::MARGIN_W-1:0]        r_safety_margin;
    gtpt_pkg::t_track_state               r_state;
    gtpt_pkg::t_track_state               n_state;
    logic                                 r_in_vld;
    logic [gtpt_pkg::REQ_W-1:0]           r_in_req;
    logic [gtpt_pkg::POS_W-1:0]           r_in_now;
    logic [gtpt_pkg::POS_W-1:0]           r_in_saved;
    logic                                 r_out_vld;
    logic [gtpt_pkg::CMD_W-1:0]           r_out_cmd;
    logic [gtpt_pkg::POS_W-1:0]           r_out_final;
    logic [gtpt_pkg::CMD_W-1:0]           n_cmd;
    logic                                 advance;
    logic                                 fire;

    assign slow_margin_we   = i_cfg_we && (i_cfg_addr == gtpt_pkg::CFG_SLOW_MARGIN);
    assign advance          = !r_out_vld || i_m_axis_tready;
    assign fire             = r_in_vld && advance;
    assign o_s_axis_tready  = !r_in_vld || advance;
    assign o_m_axis_tvalid  = r_out_vld;
    assign o_m_axis_tdata   = {6'd0, r_out_final, r_out_cmd};

    gtpt_step #(
        .BASE_OFFSET (BASE_OFFSET)
    ) u_step (
        .i_state         (r_state),
        .i_req           (r_in_req),
        .i_now           (r_in_now),
        .i_saved         (r_in_saved),
        .i_slow_margin   (r_slow_margin),
        .i_safety_margin (r_safety_margin),
        .o_state         (n_state),
        .o_cmd           (n_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_margin   <= gtpt_pkg::SLOW_MARGIN_RST;
            r_safety_margin <= gtpt_pkg::SAFETY_MARGIN_RST;
            r_state         <= '0;
            r_in_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            if (slow_margin_we) begin
                r_slow_margin <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_addr == gtpt_pkg::CFG_SAFETY_MARGIN)) begin
                r_safety_margin <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_req   <= i_s_axis_tuser;
            r_in_now   <= i_s_axis_tdata[31:0];
            r_in_saved <= i_s_axis_tdata[63:32];
        end
        if (fire) begin
            r_out_cmd   <= n_cmd;
            r_out_final <= n_state.end_pos;
        end
    end

endmodule

`default_nettype wire
